// ===== rtl/core/pperl_pkg.sv =====
package pperl_pkg;

  localparam int PORT_W    = 16;
  localparam int EPOCH_W   = 48;
  localparam int COUNT_W   = 16;
  localparam int OUTCOME_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hffff;
  localparam logic [COUNT_W-1:0] COUNT_ONE   = 16'd1;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EPOCH_VALID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_EPOCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT   = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUT_NEW      = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_COUNTED  = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DROPPED  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_NO_EPOCH = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic start;   // item accepted: latch key, clear scan trackers
    logic scan;    // issue table read at scan index
    logic commit;  // apply table update and load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic epoch_on;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/pperl_ctrl.sv =====
module pperl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pperl_pkg::sts_t sts,
  output pperl_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.epoch_on ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read's data is checked here
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/pperl_dpath.sv =====
module pperl_dpath #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pperl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pperl_pkg::CFG_W-1:0]          cfg_data,
  input  logic [pperl_pkg::PORT_W-1:0]         udp_port,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 pass,
  output logic [pperl_pkg::OUTCOME_W-1:0]      outcome,
  input  pperl_pkg::cmd_t                      cmd,
  output pperl_pkg::sts_t                      sts
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // configuration
  logic                             epoch_valid;
  logic [pperl_pkg::EPOCH_W-1:0]    current_epoch;
  logic [pperl_pkg::COUNT_W-1:0]    burst_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_valid   <= 1'b0;
      current_epoch <= '0;
      burst_limit   <= pperl_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pperl_pkg::REG_EPOCH_VALID:   epoch_valid   <= cfg_data[0];
        pperl_pkg::REG_CURRENT_EPOCH: current_epoch <= cfg_data[pperl_pkg::EPOCH_W-1:0];
        pperl_pkg::REG_BURST_LIMIT:   burst_limit   <= cfg_data[pperl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // table: valid bits in flops, payload in a single-read-port memory
  logic [TABLE_ENTRIES-1:0]      entry_valid;
  logic [pperl_pkg::PORT_W-1:0]  mem_port  [TABLE_ENTRIES];
  logic [pperl_pkg::EPOCH_W-1:0] mem_epoch [TABLE_ENTRIES];
  logic [pperl_pkg::COUNT_W-1:0] mem_count [TABLE_ENTRIES];

  logic [pperl_pkg::PORT_W-1:0]  rd_port;
  logic [pperl_pkg::EPOCH_W-1:0] rd_epoch;
  logic [pperl_pkg::COUNT_W-1:0] rd_count;

  logic [pperl_pkg::PORT_W-1:0]  key;
  logic [IDX_W-1:0]              rd_idx;
  logic [IDX_W-1:0]              chk_idx;
  logic                          chk_valid;

  logic                          hit;
  logic [IDX_W-1:0]              hit_idx;
  logic [pperl_pkg::EPOCH_W-1:0] hit_epoch;
  logic [pperl_pkg::COUNT_W-1:0] hit_count;
  logic                          free;
  logic [IDX_W-1:0]              free_idx;

  // update decision
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;
  logic [pperl_pkg::COUNT_W-1:0] wr_count;
  logic                          res_pass;
  logic [pperl_pkg::OUTCOME_W-1:0] res_outcome;

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_port  <= mem_port[rd_idx];
      rd_epoch <= mem_epoch[rd_idx];
      rd_count <= mem_count[rd_idx];
    end
    if (cmd.commit && wr_en) begin
      mem_port[wr_idx]  <= key;
      mem_epoch[wr_idx] <= current_epoch;
      mem_count[wr_idx] <= wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit && wr_en) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      chk_valid <= 1'b0;
      hit       <= 1'b0;
      free      <= 1'b0;
    end else begin
      chk_valid <= cmd.scan;
      if (cmd.start) begin
        rd_idx <= '0;
        hit    <= 1'b0;
        free   <= 1'b0;
      end else begin
        if (cmd.scan) begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
        // first matching valid entry, first invalid entry
        if (chk_valid) begin
          if (entry_valid[chk_idx]) begin
            if (!hit && rd_port == key) begin
              hit <= 1'b1;
            end
          end else if (!free) begin
            free <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= udp_port;
    end
    if (cmd.scan) begin
      chk_idx <= rd_idx;
    end
    if (chk_valid) begin
      if (entry_valid[chk_idx]) begin
        if (!hit && rd_port == key) begin
          hit_idx   <= chk_idx;
          hit_epoch <= rd_epoch;
          hit_count <= rd_count;
        end
      end else if (!free) begin
        free_idx <= chk_idx;
      end
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    wr_count    = pperl_pkg::COUNT_ONE;
    res_pass    = 1'b1;
    res_outcome = pperl_pkg::OUT_NO_EPOCH;
    if (epoch_valid) begin
      if (!hit) begin
        if (free) begin
          wr_en       = 1'b1;
          wr_idx      = free_idx;
          res_outcome = pperl_pkg::OUT_NEW;
        end else begin
          res_outcome = pperl_pkg::OUT_FULL;
        end
      end else if (hit_epoch != current_epoch) begin
        wr_en       = 1'b1;
        res_outcome = pperl_pkg::OUT_NEW;
      end else if (hit_count > burst_limit) begin
        res_pass    = 1'b0;
        res_outcome = pperl_pkg::OUT_DROPPED;
      end else begin
        wr_en       = 1'b1;
        wr_count    = (hit_count == pperl_pkg::COUNT_MAX) ? hit_count
                                                         : hit_count + pperl_pkg::COUNT_ONE;
        res_outcome = pperl_pkg::OUT_COUNTED;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pass    <= res_pass;
      outcome <= res_outcome;
    end
  end

  assign sts.epoch_on  = epoch_valid;
  assign sts.scan_last = (rd_idx == LAST_IDX);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/core/per_port_epoch_rate_limiter_top.sv =====
// Per-port fixed-window rate limiter. Each item is a UDP source port; the block
// answers with pass/drop and an outcome code, one result per item. The port
// table has TABLE_ENTRIES entries held in a single-read-port memory that is
// scanned one entry a cycle. With an epoch set, an item is accepted, every entry
// is read in turn, the data of the last read is checked, and the result is then
// loaded; with no epoch set the scan is skipped and the result is loaded after
// acceptance. The block holds one item at a time; the next
// item is accepted in the cycle after a result is loaded, while that result may
// still wait in the output register; an item that finishes while a result still
// waits holds its own result back until the waiting one is taken.
// Valid marks of the table clear at reset; no clearing pass is needed.
module per_port_epoch_rate_limiter_top #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pperl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pperl_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pperl_pkg::PORT_W-1:0]     udp_port,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             pass,
  output logic [pperl_pkg::OUTCOME_W-1:0]  outcome
);

  pperl_pkg::cmd_t cmd;
  pperl_pkg::sts_t sts;

  pperl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pperl_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .udp_port  (udp_port),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pass      (pass),
    .outcome   (outcome),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/core/pperl_checker.sv =====
module pperl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            pass,
  input logic [pperl_pkg::OUTCOME_W-1:0] outcome
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pass) && $stable(outcome))
    else $error("result changed while stalled");

  // only a dropped item is refused
  a_pass_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pass == (outcome != pperl_pkg::OUT_DROPPED)))
    else $error("pass disagrees with outcome");

  // one item in flight: busy right after an acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // a fresh result appears as the block turns idle again
  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result appeared outside item completion");

endmodule

bind per_port_epoch_rate_limiter_top pperl_checker u_pperl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pass      (pass),
  .outcome   (outcome)
);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 8;
  localparam int STEADY_RUN  = 60;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_LEN   = 90;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 2 * (ENTRIES + 3);

  localparam logic [pperl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [pperl_pkg::EPOCH_W-1:0]   EPOCH_TOP  = {pperl_pkg::EPOCH_W{1'b1}};

  typedef enum logic [1:0] {ACT_PACKET, ACT_REG_WRITE, ACT_DRAIN} act_t;

  typedef struct {
    act_t                            act;
    logic [pperl_pkg::PORT_W-1:0]    port;
    logic [pperl_pkg::CFG_IDX_W-1:0] idx;
    logic [pperl_pkg::CFG_W-1:0]     data;
    bit                              steady;
  } job_t;

  typedef struct packed {
    logic                            pass;
    logic [pperl_pkg::OUTCOME_W-1:0] outcome;
  } verdict_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [pperl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pperl_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [pperl_pkg::PORT_W-1:0]    udp_port  = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            pass;
  logic [pperl_pkg::OUTCOME_W-1:0] outcome;

  per_port_epoch_rate_limiter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .udp_port  (udp_port),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pass      (pass),
    .outcome   (outcome)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus still to be driven, and verdicts owed by the block
  job_t     arrivals [$];
  verdict_t verdicts_due [$];

  int total_jobs = 0;
  int n_fed      = 0;
  int n_sent     = 0;
  int n_done     = 0;
  int n_writes   = 0;
  int n_bad      = 0;
  int quiet      = 0;
  int seen [8];
  bit steady     = 1'b0;

  logic [pperl_pkg::PORT_W-1:0] tracked [ENTRIES];

  // limiter state as the block should hold it
  logic                          epoch_on;
  logic [pperl_pkg::EPOCH_W-1:0] window;
  logic [pperl_pkg::COUNT_W-1:0] limit;
  logic                          tbl_valid [ENTRIES];
  logic [pperl_pkg::PORT_W-1:0]  tbl_port  [ENTRIES];
  logic [pperl_pkg::EPOCH_W-1:0] tbl_epoch [ENTRIES];
  logic [pperl_pkg::COUNT_W-1:0] tbl_count [ENTRIES];

  function automatic verdict_t judge_packet(logic [pperl_pkg::PORT_W-1:0] port);
    verdict_t r;
    int       hit;
    int       spare;
    hit       = -1;
    spare     = -1;
    r.pass    = 1'b1;
    r.outcome = pperl_pkg::OUT_NO_EPOCH;
    if (epoch_on) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (tbl_valid[k]) begin
          if (hit < 0 && tbl_port[k] == port) hit = k;
        end else if (spare < 0) begin
          spare = k;
        end
      end
      if (hit < 0 && spare < 0) begin
        r.outcome = pperl_pkg::OUT_FULL;
      end else if (hit < 0) begin
        tbl_valid[spare] = 1'b1;
        tbl_port[spare]  = port;
        tbl_epoch[spare] = window;
        tbl_count[spare] = pperl_pkg::COUNT_ONE;
        r.outcome        = pperl_pkg::OUT_NEW;
      end else if (tbl_epoch[hit] != window) begin
        tbl_epoch[hit] = window;
        tbl_count[hit] = pperl_pkg::COUNT_ONE;
        r.outcome      = pperl_pkg::OUT_NEW;
      end else if (tbl_count[hit] > limit) begin
        r.pass    = 1'b0;
        r.outcome = pperl_pkg::OUT_DROPPED;
      end else begin
        if (tbl_count[hit] != pperl_pkg::COUNT_MAX)
          tbl_count[hit] = tbl_count[hit] + pperl_pkg::COUNT_ONE;
        r.outcome = pperl_pkg::OUT_COUNTED;
      end
    end
    return r;
  endfunction

  function void flag(string msg);
    n_bad++;
    if (n_bad <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function void add_job(act_t a, logic [pperl_pkg::PORT_W-1:0] p,
                        logic [pperl_pkg::CFG_IDX_W-1:0] i,
                        logic [pperl_pkg::CFG_W-1:0] d, bit st);
    job_t j;
    j.act    = a;
    j.port   = p;
    j.idx    = i;
    j.data   = d;
    j.steady = st;
    arrivals.push_back(j);
  endfunction

  always @(posedge clk) begin : drive
    logic     took;
    logic     hold;
    logic     v_n;
    logic     we_n;
    int       in_flight;
    job_t     j;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
      epoch_on = 1'b0;
      window   = '0;
      limit    = pperl_pkg::LIMIT_RESET;
      for (int k = 0; k < ENTRIES; k++) tbl_valid[k] = 1'b0;
    end else begin
      took = in_valid && in_ready;
      hold = in_valid && !in_ready;
      v_n  = hold;
      we_n = 1'b0;
      if (took) begin
        verdicts_due.push_back(judge_packet(udp_port));
        n_sent <= n_sent + 1;
      end
      in_flight = n_sent + (took ? 1 : 0) - n_done;
      if (!hold && arrivals.size() > 0) begin
        j = arrivals[0];
        case (j.act)
          ACT_PACKET: begin
            if (j.steady || $urandom_range(0, 99) >= 20) begin
              v_n = 1'b1;
              udp_port <= j.port;
              steady   <= j.steady;
              void'(arrivals.pop_front());
              n_fed <= n_fed + 1;
            end
          end
          ACT_REG_WRITE: begin
            // registers change only with nothing in flight
            if (in_flight == 0) begin
              we_n = 1'b1;
              cfg_index <= j.idx;
              cfg_data  <= j.data;
              case (j.idx)
                pperl_pkg::REG_EPOCH_VALID:   epoch_on = j.data[0];
                pperl_pkg::REG_CURRENT_EPOCH: window   = j.data[pperl_pkg::EPOCH_W-1:0];
                pperl_pkg::REG_BURST_LIMIT:   limit    = j.data[pperl_pkg::COUNT_W-1:0];
                default: ;
              endcase
              void'(arrivals.pop_front());
              n_fed    <= n_fed + 1;
              n_writes <= n_writes + 1;
            end
          end
          default: begin
            if (in_flight == 0) begin
              void'(arrivals.pop_front());
              n_fed <= n_fed + 1;
            end
          end
        endcase
      end
      in_valid <= v_n;
      cfg_we   <= we_n;
    end
  end

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_done <= n_done + 1;
        seen[outcome]++;
        if (verdicts_due.size() == 0) begin
          flag($sformatf("result %0d (pass %0b outcome %0d) with nothing expected",
                         n_done, pass, outcome));
        end else begin
          want = verdicts_due.pop_front();
          if (pass !== want.pass)
            flag($sformatf("result %0d pass: expected %0b got %0b", n_done, want.pass, pass));
          if (outcome !== want.outcome)
            flag($sformatf("result %0d outcome: expected %0d got %0d",
                           n_done, want.outcome, outcome));
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= 20;
    end
  end

  always @(posedge clk) begin : dog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("[per_port_epoch_rate_limiter_top] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : run
    logic [pperl_pkg::CFG_W-1:0]  d;
    logic [pperl_pkg::PORT_W-1:0] p;
    tracked[0] = 16'h0000;
    tracked[1] = 16'hFFFF;
    tracked[2] = 16'hAAAA;
    tracked[3] = 16'h5555;
    tracked[4] = 16'h1234;
    tracked[5] = 16'h8000;
    tracked[6] = 16'h0001;
    tracked[7] = 16'h7FFF;

    // out of reset no epoch is set, so everything passes
    add_job(ACT_PACKET, 16'h0000, '0, '0, 1'b0);
    add_job(ACT_PACKET, 16'hFFFF, '0, '0, 1'b0);
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_EPOCH_VALID, 48'd1, 1'b0);
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_CURRENT_EPOCH, 48'd0, 1'b0);
    // reset limit of 2: new, two counted, then dropped
    repeat (4) add_job(ACT_PACKET, 16'h0000, '0, '0, 1'b0);
    for (int k = 1; k < ENTRIES; k++) add_job(ACT_PACKET, tracked[k], '0, '0, 1'b0);
    add_job(ACT_DRAIN, '0, '0, '0, 1'b0);
    // table now full: a stranger goes untracked, a known port still counts
    add_job(ACT_PACKET, 16'h4321, '0, '0, 1'b0);
    add_job(ACT_PACKET, 16'hFFFF, '0, '0, 1'b0);
    // new window refreshes the entry but frees nothing
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_CURRENT_EPOCH, EPOCH_TOP, 1'b0);
    add_job(ACT_PACKET, 16'h0000, '0, '0, 1'b0);
    add_job(ACT_PACKET, 16'h4321, '0, '0, 1'b0);
    // only the low 16 bits land: limit 0 drops a count of 1
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_BURST_LIMIT, 48'hFFFF_FFFF_0000, 1'b0);
    add_job(ACT_PACKET, 16'h0000, '0, '0, 1'b0);
    add_job(ACT_REG_WRITE, '0, REG_UNUSED, 48'h0000_0000_FFFF, 1'b0);
    add_job(ACT_PACKET, 16'h0000, '0, '0, 1'b0);
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_EPOCH_VALID, 48'hFFFF_FFFF_FFFE, 1'b0);
    add_job(ACT_PACKET, 16'h0001, '0, '0, 1'b0);

    // long unbroken run on one port under the widest limit; a lower limit then drops it
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_EPOCH_VALID, 48'd1, 1'b0);
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_CURRENT_EPOCH, 48'h8000_0000_0000, 1'b0);
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_BURST_LIMIT, 48'h0000_0000_FFFF, 1'b0);
    for (int k = 0; k < STEADY_RUN; k++) add_job(ACT_PACKET, 16'h8000, '0, '0, 1'b1);
    add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_BURST_LIMIT, 48'd30, 1'b0);
    add_job(ACT_PACKET, 16'h8000, '0, '0, 1'b0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      d    = {$urandom, 16'($urandom)};
      d[0] = ($urandom_range(0, 5) != 0);
      add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_EPOCH_VALID, d, 1'b0);
      case ($urandom_range(0, 3))
        0: ;  // same window: counts carry over
        1: add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_CURRENT_EPOCH,
                   {16'($urandom), $urandom}, 1'b0);
        2: add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_CURRENT_EPOCH, '0, 1'b0);
        default: add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_CURRENT_EPOCH, EPOCH_TOP, 1'b0);
      endcase
      case ($urandom_range(0, 5))
        0: d = '0;
        1: d = 48'd1;
        2: d = 48'($urandom_range(2, 6));
        3: d = 48'($urandom_range(0, 40));
        4: d = 48'hFFFF;
        default: d = 48'($urandom);
      endcase
      d[pperl_pkg::CFG_W-1:pperl_pkg::COUNT_W] = {$urandom};
      add_job(ACT_REG_WRITE, '0, pperl_pkg::REG_BURST_LIMIT, d, 1'b0);
      if (ph % 4 == 2) add_job(ACT_REG_WRITE, '0, REG_UNUSED, {16'($urandom), $urandom}, 1'b0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2 && ph % 3 == 1) add_job(ACT_DRAIN, '0, '0, '0, 1'b0);
        p = ($urandom_range(0, 4) != 0) ? tracked[$urandom_range(0, ENTRIES - 1)]
                                        : 16'($urandom);
        add_job(ACT_PACKET, p, '0, '0, ph == 3 || ph == 4);
      end
    end
    total_jobs = arrivals.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (n_fed != total_jobs || in_valid || n_sent != n_done);
    repeat (SETTLE) @(posedge clk);
    if (verdicts_due.size() != 0)
      flag($sformatf("%0d results never arrived, oldest pass %0b outcome %0d",
                     verdicts_due.size(), verdicts_due[0].pass, verdicts_due[0].outcome));

    $display("%0d packets over %0d register writes: %0d new/refreshed, %0d counted,",
             n_sent, n_writes, seen[pperl_pkg::OUT_NEW], seen[pperl_pkg::OUT_COUNTED]);
    $display("%0d dropped, %0d untracked with table full, %0d with no epoch; %0d mismatches",
             seen[pperl_pkg::OUT_DROPPED], seen[pperl_pkg::OUT_FULL],
             seen[pperl_pkg::OUT_NO_EPOCH], n_bad);
    if (n_bad == 0) begin
      $display("[per_port_epoch_rate_limiter_top] OK");
    end else begin
      $display("[per_port_epoch_rate_limiter_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== per_port_epoch_rate_limiter_top.f =====
rtl/core/pperl_pkg.sv
rtl/core/pperl_ctrl.sv
rtl/core/pperl_dpath.sv
rtl/core/per_port_epoch_rate_limiter_top.sv
rtl/core/pperl_checker.sv
dv/testbench.sv
